// ===== sv/cdau_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cdau_pkg;

   // field widths
   localparam int YearInW  = 14;
   localparam int YearW    = 21;
   localparam int MonthW   = 4;
   localparam int DayW     = 5;
   localparam int HourW    = 5;
   localparam int MinuteW  = 6;
   localparam int AmountW  = 24;

   // shared divider geometry
   localparam int DivW     = 25;
   localparam int DivisorW = 9;
   localparam int RecipW   = 26;
   localparam int ShiftW   = 6;
   localparam int ProdW    = DivW + RecipW;

   // whole days left after the minute and hour carries
   localparam int DaysW    = 15;

   localparam logic [MonthW-1:0]   MaxMonth      = 4'd11;
   localparam logic [MonthW-1:0]   FebMonth      = 4'd1;
   localparam logic [DayW-1:0]     LeapFebLen    = 5'd29;
   localparam logic [DivisorW-1:0] YearCycle     = 9'd400;
   localparam logic [DivisorW-1:0] CenturyLen    = 9'd100;
   localparam logic [DivisorW-1:0] MinutesPerHour = 9'd60;
   localparam logic [DivisorW-1:0] HoursPerDay   = 9'd24;
   localparam logic [DivisorW-1:0] MonthsPerYear = 9'd12;

   // scaled reciprocals, rounded up, exact for any dividend below 2**DivW
   localparam logic [RecipW-1:0] RecipMinutes = 26'd35791395;  // 2**31 / 60
   localparam logic [ShiftW-1:0] ShiftMinutes = 6'd31;
   localparam logic [RecipW-1:0] RecipHours   = 26'd44739243;  // 2**30 / 24
   localparam logic [ShiftW-1:0] ShiftHours   = 6'd30;
   localparam logic [RecipW-1:0] RecipMonths  = 26'd44739243;  // 2**29 / 12
   localparam logic [ShiftW-1:0] ShiftMonths  = 6'd29;
   localparam logic [RecipW-1:0] RecipYears   = 26'd42949673;  // 2**34 / 400
   localparam logic [ShiftW-1:0] ShiftYears   = 6'd34;

   typedef struct packed {
      logic                start;
      logic [DivisorW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   function automatic logic [DayW-1:0] plain_month_len(input logic [MonthW-1:0] month);
      logic [DayW-1:0] len;
      case (month)
         4'd1:                  len = 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
         default:               len = 5'd31;
      endcase
      return len;
   endfunction

   // ymod is the year modulo 400
   function automatic logic is_leap(input logic [DivisorW-1:0] ymod);
      logic century;
      century = (ymod == CenturyLen) || (ymod == DivisorW'(2 * CenturyLen)) ||
                (ymod == DivisorW'(3 * CenturyLen));
      return (ymod[1:0] == 2'b00) && !century;
   endfunction

   function automatic logic [DayW-1:0] month_len(input logic [DivisorW-1:0] ymod,
                                                 input logic [MonthW-1:0]   month);
      logic [DayW-1:0] len;
      len = plain_month_len(month);
      if (month == FebMonth && is_leap(ymod)) begin
         len = LeapFebLen;
      end
      return len;
   endfunction

endpackage

`default_nettype wire

// ===== sv/cdau_intf.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface cdau_req_if;
   logic                               valid;
   logic                               ready;
   logic                               req_type;
   logic [cdau_pkg::YearInW-1:0]       in_year;
   logic [cdau_pkg::MonthW-1:0]        in_month;
   logic [cdau_pkg::DayW-1:0]          in_day;
   logic [cdau_pkg::HourW-1:0]         in_hour;
   logic [cdau_pkg::MinuteW-1:0]       in_minute;
   logic [cdau_pkg::AmountW-1:0]       amount;

   modport source (output valid, req_type, in_year, in_month, in_day, in_hour, in_minute,
                   amount, input ready);
   modport sink   (input valid, req_type, in_year, in_month, in_day, in_hour, in_minute,
                   amount, output ready);
endinterface

interface cdau_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [cdau_pkg::YearW-1:0]         out_year;
   logic [cdau_pkg::MonthW-1:0]        out_month;
   logic [cdau_pkg::DayW-1:0]          out_day;
   logic [cdau_pkg::HourW-1:0]         out_hour;
   logic [cdau_pkg::MinuteW-1:0]       out_minute;

   modport source (output valid, out_year, out_month, out_day, out_hour, out_minute,
                   input ready);
   modport sink   (input valid, out_year, out_month, out_day, out_hour, out_minute,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/cdau_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// divider for the fixed divisors: multiply by a scaled reciprocal, shift down
// for the quotient, multiply back for the remainder; done rises with the registered remainder
module cdau_div (
   input  logic                          clock,
   input  logic                          reset,
   input  cdau_pkg::div_req_type         div_req,
   input  logic [cdau_pkg::DivW-1:0]     dividend,
   output cdau_pkg::div_stat_type        div_stat,
   output logic [cdau_pkg::DivW-1:0]     quotient,
   output logic [cdau_pkg::DivisorW-1:0] remainder
);
   import cdau_pkg::*;

   typedef enum logic [3:0] {
      D_IDLE = 4'b0001,
      D_MUL  = 4'b0010,
      D_QUO  = 4'b0100,
      D_REM  = 4'b1000
   } div_step_type;

   div_step_type        step_ff, step_in;
   logic                done_ff, done_in;
   logic [DivW-1:0]     num_ff;
   logic [DivisorW-1:0] divisor_ff;
   logic [ProdW-1:0]    prod_ff;
   logic [DivW-1:0]     quo_ff;
   logic [DivisorW-1:0] rem_ff;

   logic [RecipW-1:0]   recip;
   logic [ShiftW-1:0]   shift;
   logic [ProdW-1:0]    prod_in;
   logic [ProdW-1:0]    quo_full;
   logic [DivW-1:0]     back_prod;
   logic [DivW-1:0]     rem_full;

   // reciprocal and shift for the divisor in hand
   always_comb begin
      unique case (divisor_ff)
         HoursPerDay: begin
            recip = RecipHours;
            shift = ShiftHours;
         end
         MonthsPerYear: begin
            recip = RecipMonths;
            shift = ShiftMonths;
         end
         YearCycle: begin
            recip = RecipYears;
            shift = ShiftYears;
         end
         default: begin
            recip = RecipMinutes;
            shift = ShiftMinutes;
         end
      endcase
   end

   assign prod_in   = ProdW'(num_ff) * ProdW'(recip);
   assign quo_full  = prod_ff >> shift;
   assign back_prod = quo_ff * DivW'(divisor_ff);
   assign rem_full  = num_ff - back_prod;

   always_comb begin
      step_in = step_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         step_in = D_MUL;
      end else begin
         unique case (step_ff)
            D_IDLE: step_in = D_IDLE;
            D_MUL:  step_in = D_QUO;
            D_QUO:  step_in = D_REM;
            D_REM: begin
               step_in = D_IDLE;
               done_in = 1'b1;
            end
            default: step_in = D_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= D_IDLE;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         num_ff     <= dividend;
         divisor_ff <= div_req.divisor;
      end
      if (step_ff == D_MUL) begin
         prod_ff <= prod_in;
      end
      if (step_ff == D_QUO) begin
         quo_ff <= quo_full[DivW-1:0];
      end
      if (step_ff == D_REM) begin
         rem_ff <= rem_full[DivisorW-1:0];
      end
   end

   assign div_stat.busy = (step_ff != D_IDLE);
   assign div_stat.done = done_ff;
   assign quotient      = quo_ff;
   assign remainder     = rem_ff;

endmodule

`default_nettype wire

// ===== sv/calendar_date_advance_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Advances a Gregorian date and time by a number of minutes (req_type 0) or
// months (req_type 1) and returns one result per request transfer. One request
// is worked at a time; req ready is high only while the sequencer is idle, and
// a finished result waits in the output register so the next request may be
// taken meanwhile; a result that reaches completion while the previous one is
// still held by the receiver waits in the done state, and so does the next request.
// Every request goes through the shared divider (reciprocal multiply, shift,
// multiply back, each step registered): minute mode divides by 60, by 24 and by
// 400 (year phase), then walks one month per cycle (the largest amount
// crosses some 383 months); month mode divides by 12 and by 400.
// Months 12 to 15 are read as December and day 0 as day 1.
module calendar_date_advance_unit (
   input  logic       clock,
   input  logic       reset,
   cdau_req_if.sink   req_ch,
   cdau_rsp_if.source rsp_ch
);
   import cdau_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_DIV_MIN  = 9'b000000010,
      S_DIV_HOUR = 9'b000000100,
      S_DIV_MON  = 9'b000001000,
      S_DIV_YEAR = 9'b000010000,
      S_CLAMP    = 9'b000100000,
      S_WALK     = 9'b001000000,
      S_FIX      = 9'b010000000,
      S_DONE     = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // working date
   logic                mode_ff,   mode_in;
   logic [YearW-1:0]    year_ff,   year_in;
   logic [MonthW-1:0]   month_ff,  month_in;
   logic [DayW-1:0]     day_ff,    day_in;
   logic [HourW-1:0]    hour_ff,   hour_in;
   logic [MinuteW-1:0]  minute_ff, minute_in;
   logic [DaysW-1:0]    days_ff,   days_in;
   logic [DivisorW-1:0] ymod_ff,   ymod_in;
   logic                at_end_ff, at_end_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [YearW-1:0]    rsp_year_ff;
   logic [MonthW-1:0]   rsp_month_ff;
   logic [DayW-1:0]     rsp_day_ff;
   logic [HourW-1:0]    rsp_hour_ff;
   logic [MinuteW-1:0]  rsp_minute_ff;
   logic                rsp_load;

   // shared divider
   div_req_type         div_req;
   div_stat_type        div_stat;
   logic [DivW-1:0]     dividend;
   logic [DivW-1:0]     quotient;
   logic [DivisorW-1:0] remainder;

   logic                req_xfer;
   logic [MonthW-1:0]   start_month;
   logic [DayW-1:0]     start_day;
   logic [DayW-1:0]     len_cur;
   logic [DaysW:0]      walk_sum;
   logic [DayW-1:0]     walk_step;
   logic [YearW-1:0]    year_sum;

   cdau_div u_div (
      .clock     (clock),
      .reset     (reset),
      .div_req   (div_req),
      .dividend  (dividend),
      .div_stat  (div_stat),
      .quotient  (quotient),
      .remainder (remainder)
   );

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_xfer     = req_ch.valid && req_ch.ready;

   // out-of-range month reads as december, day zero as the first
   assign start_month = (req_ch.in_month > MaxMonth) ? MaxMonth : req_ch.in_month;
   assign start_day   = (req_ch.in_day == '0) ? DayW'(1) : req_ch.in_day;

   // length of the month being visited, leap february from year mod 400
   assign len_cur   = month_len(ymod_ff, month_ff);
   assign walk_sum  = (DaysW + 1)'(day_ff) + (DaysW + 1)'(days_ff);
   assign walk_step = len_cur - day_ff + DayW'(1);
   assign year_sum  = year_ff + quotient[YearW-1:0];

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      year_in   = year_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      days_in   = days_ff;
      ymod_in   = ymod_ff;
      at_end_in = at_end_ff;
      div_req   = '{start: 1'b0, divisor: MinutesPerHour};
      dividend  = '0;
      rsp_load  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               mode_in   = req_ch.req_type;
               year_in   = YearW'(req_ch.in_year);
               month_in  = start_month;
               day_in    = start_day;
               hour_in   = req_ch.in_hour;
               minute_in = req_ch.in_minute;
               // end of month judged on the plain table
               at_end_in = (start_day == plain_month_len(start_month));
               div_req.start = 1'b1;
               if (req_ch.req_type) begin
                  div_req.divisor = MonthsPerYear;
                  dividend = DivW'(req_ch.amount) + DivW'(start_month);
                  state_in = S_DIV_MON;
               end else begin
                  div_req.divisor = MinutesPerHour;
                  dividend = DivW'(req_ch.amount) + DivW'(req_ch.in_minute);
                  state_in = S_DIV_MIN;
               end
            end
         end
         S_DIV_MIN: begin
            if (div_stat.done) begin
               minute_in     = remainder[MinuteW-1:0];
               div_req.start = 1'b1;
               div_req.divisor = HoursPerDay;
               dividend = quotient + DivW'(hour_ff);
               state_in = S_DIV_HOUR;
            end
         end
         S_DIV_HOUR: begin
            if (div_stat.done) begin
               hour_in       = remainder[HourW-1:0];
               days_in       = quotient[DaysW-1:0];
               div_req.start = 1'b1;
               div_req.divisor = YearCycle;
               dividend = DivW'(year_ff);
               state_in = S_DIV_YEAR;
            end
         end
         S_DIV_MON: begin
            if (div_stat.done) begin
               month_in      = remainder[MonthW-1:0];
               year_in       = year_sum;
               div_req.start = 1'b1;
               div_req.divisor = YearCycle;
               dividend = DivW'(year_sum);
               state_in = S_DIV_YEAR;
            end
         end
         S_DIV_YEAR: begin
            if (div_stat.done) begin
               ymod_in  = remainder;
               state_in = mode_ff ? S_FIX : S_CLAMP;
            end
         end
         S_CLAMP: begin
            // start day past the end of its month
            if (day_ff > len_cur) begin
               day_in = len_cur;
            end
            state_in = S_WALK;
         end
         S_WALK: begin
            if (walk_sum > (DaysW + 1)'(len_cur)) begin
               days_in = days_ff - DaysW'(walk_step);
               day_in  = DayW'(1);
               if (month_ff == MaxMonth) begin
                  month_in = '0;
                  year_in  = year_ff + YearW'(1);
                  ymod_in  = (ymod_ff == YearCycle - 1'b1) ? '0 : ymod_ff + 1'b1;
               end else begin
                  month_in = month_ff + 1'b1;
               end
            end else begin
               day_in   = walk_sum[DayW-1:0];
               state_in = S_DONE;
            end
         end
         S_FIX: begin
            // snap to month end, or clamp a day the target month lacks
            if (at_end_ff || day_ff > len_cur) begin
               day_in = len_cur;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      year_ff   <= year_in;
      month_ff  <= month_in;
      day_ff    <= day_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
      days_ff   <= days_in;
      ymod_ff   <= ymod_in;
      at_end_ff <= at_end_in;
      if (rsp_load) begin
         rsp_year_ff   <= year_ff;
         rsp_month_ff  <= month_ff;
         rsp_day_ff    <= day_ff;
         rsp_hour_ff   <= hour_ff;
         rsp_minute_ff <= minute_ff;
      end
   end

   // result channel
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_year   = rsp_year_ff;
   assign rsp_ch.out_month  = rsp_month_ff;
   assign rsp_ch.out_day    = rsp_day_ff;
   assign rsp_ch.out_hour   = rsp_hour_ff;
   assign rsp_ch.out_minute = rsp_minute_ff;

`ifndef SYNTH
   // divider is never restarted mid-division
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_stat.busy)
      else $error("divider started while busy");

   // a finished division is only seen while the sequencer waits on it
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_DIV_MIN || state_ff == S_DIV_HOUR ||
                         state_ff == S_DIV_MON || state_ff == S_DIV_YEAR))
      else $error("division finished outside a divide phase");

   // month walk keeps a legal date in hand
   a_walk_date: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK |-> (ymod_ff < YearCycle && month_ff <= MaxMonth &&
                              day_ff != '0 && day_ff <= len_cur))
      else $error("illegal date during month walk");

   // each request transfer starts a division
   a_req_starts: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff == S_DIV_MIN || state_ff == S_DIV_MON))
      else $error("request transfer did not start the sequencer");

   // a new result only follows a completed sequence
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside completion");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_calendar_date_advance_unit.sv =====
`timescale 1ns / 1ps

module tb_calendar_date_advance_unit;
   import cdau_pkg::*;

   // watchdog: cycles without any transfer on either channel
   localparam int StallLimit  = 4000;
   // quiet time after the last result, longer than the slowest minute walk
   localparam int SettleCycles = 600;
   localparam int PhaseItems  = 250;

   typedef enum logic {
      ADD_MINUTES = 1'b0,
      ADD_MONTHS  = 1'b1
   } advance_mode_type;

   typedef struct packed {
      advance_mode_type    mode;
      logic [YearInW-1:0]  year;
      logic [MonthW-1:0]   month;
      logic [DayW-1:0]     day;
      logic [HourW-1:0]    hour;
      logic [MinuteW-1:0]  minute;
      logic [AmountW-1:0]  amount;
   } advance_req_type;

   typedef struct packed {
      logic [YearW-1:0]    year;
      logic [MonthW-1:0]   month;
      logic [DayW-1:0]     day;
      logic [HourW-1:0]    hour;
      logic [MinuteW-1:0]  minute;
   } date_result_type;

   logic clock = 1'b0;
   logic reset;

   cdau_req_if req_if ();
   cdau_rsp_if rsp_if ();

   calendar_date_advance_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   always #10 clock = ~clock;

   advance_req_type pending_reqs[$];    // waiting to be offered to the block
   date_result_type expected_dates[$];  // predicted for accepted requests
   advance_req_type cur_req;            // request currently on the input channel

   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int unsigned mismatch_count;
   int unsigned minute_reqs;
   int unsigned month_reqs;
   int unsigned checked_results;
   int unsigned quiet_cycles;

   // ---------------------------------------------------------------------
   // date arithmetic
   // ---------------------------------------------------------------------

   function automatic bit leap_year(input int unsigned y);
      return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
   endfunction

   // month length ignoring leap years
   function automatic int unsigned plain_days(input int unsigned m);
      case (m)
         1:             return 28;
         3, 5, 8, 10:   return 30;
         default:       return 31;
      endcase
   endfunction

   function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
      if (m == 32'(FebMonth) && leap_year(y)) begin
         return 32'(LeapFebLen);
      end
      return plain_days(m);
   endfunction

   // expected new date for one request
   function automatic date_result_type advance_date(input advance_req_type r);
      int unsigned year, month, day, hour, minute, n, len, total;
      bit at_end;
      date_result_type res;
      year   = 32'(r.year);
      // months past december read as december, day zero as the first
      month  = (r.month > MaxMonth) ? 32'(MaxMonth) : 32'(r.month);
      day    = (r.day == '0) ? 1 : 32'(r.day);
      hour   = 32'(r.hour);
      minute = 32'(r.minute);
      n      = 32'(r.amount);
      if (r.mode == ADD_MINUTES) begin
         // carry minutes into hours, hours into whole days
         n      = n + minute;
         minute = n % 60;
         n      = n / 60 + hour;
         hour   = n % 24;
         n      = n / 24;
         len = days_in_month(year, month);
         if (day > len) begin
            day = len;
         end
         // walk the remaining days a month at a time
         while (1) begin
            len = days_in_month(year, month);
            if (day + n > len) begin
               n     = n - (len - day + 1);
               day   = 1;
               month = month + 1;
               if (month > 32'(MaxMonth)) begin
                  month = 0;
                  year  = year + 1;
               end
            end else begin
               day = day + n;
               break;
            end
         end
      end else begin
         // end of month judged on the non-leap lengths, so 28 feb counts
         at_end = (day == plain_days(month));
         total  = n + month;
         month  = total % 12;
         year   = year + total / 12;
         len    = days_in_month(year, month);
         if (at_end || day > len) begin
            day = len;
         end
      end
      res.year   = year[YearW-1:0];
      res.month  = month[MonthW-1:0];
      res.day    = day[DayW-1:0];
      res.hour   = hour[HourW-1:0];
      res.minute = minute[MinuteW-1:0];
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------

   task automatic queue_item(input advance_mode_type mode, input int unsigned y,
                             input int unsigned m, input int unsigned d,
                             input int unsigned h, input int unsigned mi,
                             input int unsigned amt);
      advance_req_type r;
      r.mode   = mode;
      r.year   = y[YearInW-1:0];
      r.month  = m[MonthW-1:0];
      r.day    = d[DayW-1:0];
      r.hour   = h[HourW-1:0];
      r.minute = mi[MinuteW-1:0];
      r.amount = amt[AmountW-1:0];
      pending_reqs.push_back(r);
   endtask

   // mostly well-formed dates near the present, with a share of odd inputs
   task automatic queue_random(input int count);
      advance_req_type r;
      int unsigned len, pick;
      repeat (count) begin
         r.mode = advance_mode_type'($urandom_range(1, 0));
         if ($urandom_range(99) < 70) begin
            r.year = YearInW'($urandom_range(2200, 1900));
         end else begin
            r.year = YearInW'($urandom_range(16383, 0));
         end
         if ($urandom_range(99) < 90) begin
            r.month = MonthW'($urandom_range(11, 0));
         end else begin
            r.month = MonthW'($urandom_range(15, 0));
         end
         len = days_in_month(32'(r.year),
                             (r.month > MaxMonth) ? 32'(MaxMonth) : 32'(r.month));
         if ($urandom_range(99) < 85) begin
            r.day = DayW'($urandom_range(len, 1));
         end else begin
            r.day = DayW'($urandom_range(31, 0));
         end
         if ($urandom_range(99) < 85) begin
            r.hour   = HourW'($urandom_range(23, 0));
            r.minute = MinuteW'($urandom_range(59, 0));
         end else begin
            r.hour   = HourW'($urandom_range(31, 0));
            r.minute = MinuteW'($urandom_range(63, 0));
         end
         pick = $urandom_range(99);
         if (r.mode == ADD_MINUTES) begin
            // long minute walks are slow, so keep most amounts modest
            if (pick < 40) begin
               r.amount = AmountW'($urandom_range(2000, 0));
            end else if (pick < 80) begin
               r.amount = AmountW'($urandom_range(1000000, 0));
            end else begin
               r.amount = AmountW'($urandom);
            end
         end else begin
            if (pick < 70) begin
               r.amount = AmountW'($urandom_range(150, 0));
            end else if (pick < 90) begin
               r.amount = AmountW'($urandom_range(5000, 0));
            end else begin
               r.amount = AmountW'($urandom);
            end
         end
         pending_reqs.push_back(r);
      end
   endtask

   // wait until every queued request has been transferred and answered
   task automatic drain();
      do begin
         @(negedge clock);
      end while (pending_reqs.size() != 0 || req_if.valid || expected_dates.size() != 0);
   endtask

   // ---------------------------------------------------------------------
   // request driver
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         // a request transfer: predict its result straight away
         if (req_if.valid && req_if.ready) begin
            expected_dates.push_back(advance_date(cur_req));
            if (cur_req.mode == ADD_MINUTES) begin
               minute_reqs++;
            end else begin
               month_reqs++;
            end
         end
         // offer the next request, or leave the channel idle
         if (!req_if.valid || req_if.ready) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_req = pending_reqs.pop_front();
               req_if.req_type  <= cur_req.mode;
               req_if.in_year   <= cur_req.year;
               req_if.in_month  <= cur_req.month;
               req_if.in_day    <= cur_req.day;
               req_if.in_hour   <= cur_req.hour;
               req_if.in_minute <= cur_req.minute;
               req_if.amount    <= cur_req.amount;
               req_if.valid     <= 1'b1;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // result monitor
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      date_result_type got, want;
      string diffs;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            got.year   = rsp_if.out_year;
            got.month  = rsp_if.out_month;
            got.day    = rsp_if.out_day;
            got.hour   = rsp_if.out_hour;
            got.minute = rsp_if.out_minute;
            if (expected_dates.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("%0t: result transfer with nothing outstanding: %0d-%0d-%0d %0d:%0d",
                           $realtime, got.year, got.month, got.day, got.hour, got.minute);
               end
            end else begin
               want = expected_dates.pop_front();
               checked_results++;
               diffs = "";
               if (got.year !== want.year) diffs = {diffs, " year"};
               if (got.month !== want.month) diffs = {diffs, " month"};
               if (got.day !== want.day) diffs = {diffs, " day"};
               if (got.hour !== want.hour) diffs = {diffs, " hour"};
               if (got.minute !== want.minute) diffs = {diffs, " minute"};
               if (diffs != "") begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: wrong%s: expected %0d-%0d-%0d %0d:%0d got %0d-%0d-%0d %0d:%0d",
                              $realtime, diffs, want.year, want.month, want.day, want.hour,
                              want.minute, got.year, got.month, got.day, got.hour,
                              got.minute);
                  end
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // watchdog
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("no transfer for %0d cycles, %0d results outstanding",
                  StallLimit, expected_dates.size());
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // sequence of the run
   // ---------------------------------------------------------------------

   initial begin
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.req_type  = ADD_MINUTES;
      req_if.in_year   = '0;
      req_if.in_month  = '0;
      req_if.in_day    = '0;
      req_if.in_hour   = '0;
      req_if.in_minute = '0;
      req_if.amount    = '0;
      rsp_if.ready     = 1'b0;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      mismatch_count   = 0;
      minute_reqs      = 0;
      month_reqs       = 0;
      checked_results  = 0;

      // directed: minute mode
      queue_item(ADD_MINUTES, 1900, 0, 1, 0, 0, 0);            // nothing to add
      queue_item(ADD_MINUTES, 16383, 11, 31, 23, 59, 24'hFFFFFF); // largest amount
      queue_item(ADD_MINUTES, 0, 1, 28, 23, 59, 1);           // year 0 is a leap year
      queue_item(ADD_MINUTES, 1900, 1, 28, 23, 59, 1);        // century, no leap day
      queue_item(ADD_MINUTES, 2000, 1, 29, 12, 0, 1440);      // leap day of a 400 year
      queue_item(ADD_MINUTES, 2100, 1, 28, 0, 0, 1440);
      queue_item(ADD_MINUTES, 2023, 15, 31, 23, 59, 1);       // month past december
      queue_item(ADD_MINUTES, 2023, 5, 0, 0, 0, 60);          // day zero
      queue_item(ADD_MINUTES, 2023, 3, 31, 0, 0, 0);          // day past april's end
      queue_item(ADD_MINUTES, 2023, 6, 15, 31, 63, 0);        // hour and minute out of range
      queue_item(ADD_MINUTES, 8191, 2, 16, 10, 42, 24'hAAAAAA);
      queue_item(ADD_MINUTES, 16383, 0, 1, 0, 0, 24'h555555);

      // directed: month mode
      queue_item(ADD_MONTHS, 2023, 0, 31, 8, 30, 0);
      queue_item(ADD_MONTHS, 2023, 0, 31, 8, 30, 1);          // clamp to 28 feb
      queue_item(ADD_MONTHS, 2024, 0, 31, 8, 30, 1);          // clamp to 29 feb
      queue_item(ADD_MONTHS, 2023, 1, 28, 0, 0, 12);          // 28 feb is end of month
      queue_item(ADD_MONTHS, 2024, 1, 29, 0, 0, 12);          // leap day into plain year
      queue_item(ADD_MONTHS, 2024, 1, 29, 0, 0, 48);          // leap day kept
      queue_item(ADD_MONTHS, 2024, 1, 29, 0, 0, 1);           // leap day is not the last
      queue_item(ADD_MONTHS, 2023, 1, 30, 0, 0, 1);           // day past february's end
      queue_item(ADD_MONTHS, 2023, 3, 30, 0, 0, 1);           // end of april to end of may
      queue_item(ADD_MONTHS, 2023, 12, 15, 0, 0, 1);          // month past december
      queue_item(ADD_MONTHS, 2023, 6, 0, 31, 63, 7);          // day zero, odd time kept
      queue_item(ADD_MONTHS, 16383, 11, 31, 23, 59, 24'hFFFFFF);
      queue_item(ADD_MONTHS, 0, 0, 31, 0, 0, 1);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      drain();

      // random phases with different pacing on each side
      send_idle_pct = 0;  recv_stall_pct = 0;
      queue_random(PhaseItems);
      drain();
      send_idle_pct = 80; recv_stall_pct = 0;
      queue_random(PhaseItems);
      drain();
      send_idle_pct = 0;  recv_stall_pct = 80;
      queue_random(PhaseItems);
      drain();
      send_idle_pct = 12; recv_stall_pct = 12;
      queue_random(PhaseItems);
      drain();

      // anything arriving now is an extra result
      repeat (SettleCycles) @(negedge clock);
      if (expected_dates.size() != 0) begin
         mismatch_count += expected_dates.size();
         $display("%0d results never arrived", expected_dates.size());
      end

      $display("ran %0d minute-mode and %0d month-mode requests over four pacing phases",
               minute_reqs, month_reqs);
      $display("checked %0d results, %0d mismatches", checked_results, mismatch_count);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
